// ===== design/twr_pkg.sv =====
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types and codes for the two-way ranging distance pipeline.
// ----------------------------------------------------------------------------
package twr_pkg;

    localparam int TS_BITS_DEF = 40;
    localparam int RAW_W       = 64;
    localparam int SCALE_W     = 32;
    localparam int MAXD_W      = 24;
    localparam int MINT_W      = 40;
    localparam int CFG_W       = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_SHIFT  = 22;

    localparam logic [31:0] SCALE_RST = 32'd20150699;
    localparam logic [23:0] MAXD_RST  = 24'd1024000;
    localparam logic [39:0] MINT_RST  = 40'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADTS = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic OP_SINGLE = 1'b0;

    typedef struct packed {
        logic             op;
        logic [RAW_W-1:0] poll_sent;
        logic [RAW_W-1:0] poll_seen;
        logic [RAW_W-1:0] reply_sent;
        logic [RAW_W-1:0] reply_seen;
        logic [RAW_W-1:0] last_sent;
        logic [RAW_W-1:0] last_seen;
    } twr_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [MAXD_W-1:0] distance_q10;
        logic              valid_res;
    } twr_out_t;

endpackage

// ===== design/twr_range_distance.sv =====
// ----------------------------------------------------------------------------
// twr_range_distance
// Distance from one single- or double-sided two-way ranging exchange.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | twr_in_t  (one exchange)
//  m_      | out       | m_valid / m_ready  | twr_out_t (one result)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
//  one request per cycle while the output is not stalled; the quotient comes
//  from the restoring divider, one quotient bit per stage
//  the whole pipeline advances when the output register is empty or taken
//  aresetn (synchronous) clears all valid bits and loads register defaults
// ----------------------------------------------------------------------------
module twr_range_distance #(
    parameter int TS_BITS = twr_pkg::TS_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  twr_pkg::twr_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output twr_pkg::twr_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [twr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twr_pkg::CFG_W-1:0]      cfg_wdata
);
    import twr_pkg::*;

    localparam int T   = TS_BITS;
    localparam int LO  = (T + 1) / 2;
    localparam int HI  = T - LO;
    localparam int DW  = T + 2;
    localparam int PW  = 2 * T;
    localparam int DSW = T + 10;
    localparam int CW  = 64;

    typedef struct packed {
        logic          op;
        logic [1:0]    st;
        logic [T-1:0]  tof_s;
        logic [DW-1:0] den;
        logic [DW-1:0] rem;
        logic [T-1:0]  num_lo;
        logic [T-1:0]  q;
    } dstage_t;

    logic [SCALE_W-1:0] scale_reg;
    logic [MAXD_W-1:0]  maxd_reg;
    logic [MINT_W-1:0]  mint_reg;

    logic pipe_en;
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RST;
            maxd_reg  <= MAXD_RST;
            mint_reg  <= MINT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_MAXD:  maxd_reg  <= cfg_wdata[MAXD_W-1:0];
                CFG_MINT:  mint_reg  <= cfg_wdata[MINT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic ts_ok(input logic [RAW_W-1:0] t);
        return (t != '0) && (t[RAW_W-1:T] == '0);
    endfunction

    // stage 1: timestamp checks and modular differences
    logic         v1_reg, op1_reg, bada1_reg, badb1_reg;
    logic [T-1:0] ra1_reg, rb1_reg, da1_reg, db1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
        end
        if (pipe_en) begin
            op1_reg   <= s_data.op;
            bada1_reg <= !ts_ok(s_data.poll_sent) || !ts_ok(s_data.poll_seen) ||
                         !ts_ok(s_data.reply_sent) || !ts_ok(s_data.reply_seen);
            badb1_reg <= !ts_ok(s_data.last_sent) || !ts_ok(s_data.last_seen);
            ra1_reg   <= T'(s_data.reply_sent - s_data.poll_seen);
            rb1_reg   <= T'(s_data.last_sent - s_data.reply_seen);
            da1_reg   <= T'(s_data.last_seen - s_data.reply_sent);
            db1_reg   <= T'(s_data.reply_seen - s_data.poll_sent);
        end
    end

    // stage 2: status of the early checks, denominator, partial products
    logic [T-1:0]  tof_s_next;
    logic [DW-1:0] den_next;
    logic [1:0]    st2_next;

    always_comb begin
        tof_s_next = T'((db1_reg - ra1_reg) >> 1);
        den_next   = DW'(ra1_reg) + DW'(rb1_reg) + DW'(da1_reg) + DW'(db1_reg);
        priority if (bada1_reg) begin
            st2_next = ST_BADTS;
        end else if (op1_reg == OP_SINGLE) begin
            priority if (db1_reg == '0 || ra1_reg == '0) st2_next = ST_BADTS;
            else if (db1_reg < ra1_reg)                  st2_next = ST_CALC;
            else if (CW'(tof_s_next) < CW'(mint_reg))    st2_next = ST_CALC;
            else                                         st2_next = ST_OK;
        end else begin
            priority if (badb1_reg) st2_next = ST_BADTS;
            else if (ra1_reg == '0 || rb1_reg == '0 || da1_reg == '0 || db1_reg == '0)
                st2_next = ST_BADTS;
            else if (CW'(den_next) < CW'(mint_reg)) st2_next = ST_CALC;
            else st2_next = ST_OK;
        end
    end

    logic               v2_reg, op2_reg;
    logic [1:0]         st2_reg;
    logic [T-1:0]       tof2_reg;
    logic [DW-1:0]      den2_reg;
    logic [2*LO-1:0]    dll_reg, rll_reg;
    logic [LO+HI-1:0]   dlh_reg, dhl_reg, rlh_reg, rhl_reg;
    logic [2*HI-1:0]    dhh_reg, rhh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
        if (pipe_en) begin
            op2_reg  <= op1_reg;
            st2_reg  <= st2_next;
            tof2_reg <= tof_s_next;
            den2_reg <= den_next;
            dll_reg  <= da1_reg[LO-1:0] * db1_reg[LO-1:0];
            dlh_reg  <= (LO+HI)'(da1_reg[LO-1:0] * db1_reg[T-1:LO]);
            dhl_reg  <= (LO+HI)'(da1_reg[T-1:LO] * db1_reg[LO-1:0]);
            dhh_reg  <= da1_reg[T-1:LO] * db1_reg[T-1:LO];
            rll_reg  <= ra1_reg[LO-1:0] * rb1_reg[LO-1:0];
            rlh_reg  <= (LO+HI)'(ra1_reg[LO-1:0] * rb1_reg[T-1:LO]);
            rhl_reg  <= (LO+HI)'(ra1_reg[T-1:LO] * rb1_reg[LO-1:0]);
            rhh_reg  <= ra1_reg[T-1:LO] * rb1_reg[T-1:LO];
        end
    end

    // stage 3: full products
    logic          v3_reg, op3_reg;
    logic [1:0]    st3_reg;
    logic [T-1:0]  tof3_reg;
    logic [DW-1:0] den3_reg;
    logic [PW-1:0] dadb3_reg, rarb3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= v2_reg;
        end
        if (pipe_en) begin
            op3_reg   <= op2_reg;
            st3_reg   <= st2_reg;
            tof3_reg  <= tof2_reg;
            den3_reg  <= den2_reg;
            dadb3_reg <= (PW'(dhh_reg) << (2 * LO)) + (PW'(dlh_reg) << LO) +
                         (PW'(dhl_reg) << LO) + PW'(dll_reg);
            rarb3_reg <= (PW'(rhh_reg) << (2 * LO)) + (PW'(rlh_reg) << LO) +
                         (PW'(rhl_reg) << LO) + PW'(rll_reg);
        end
    end

    // stage 4: numerator sign and divider seed
    logic [PW-1:0] num_next;
    dstage_t       seed_next;

    always_comb begin
        num_next         = dadb3_reg - rarb3_reg;
        seed_next.op     = op3_reg;
        seed_next.st     = (op3_reg != OP_SINGLE && st3_reg == ST_OK &&
                            dadb3_reg < rarb3_reg) ? ST_CALC : st3_reg;
        seed_next.tof_s  = tof3_reg;
        seed_next.den    = den3_reg;
        seed_next.rem    = DW'(num_next[PW-1:T]);
        seed_next.num_lo = num_next[T-1:0];
        seed_next.q      = '0;
    end

    // restoring divider, one quotient bit per stage
    logic    dv_reg [T+1];
    dstage_t ds_reg [T+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            dv_reg[0] <= v3_reg;
        end
        if (pipe_en) begin
            ds_reg[0] <= seed_next;
        end
    end

    for (genvar k = 0; k < T; k++) begin : g_div
        logic [DW:0] trial;
        logic        ge;
        dstage_t     ds_next;

        always_comb begin
            trial          = {ds_reg[k].rem, ds_reg[k].num_lo[T-1]};
            ge             = trial >= {1'b0, ds_reg[k].den};
            ds_next        = ds_reg[k];
            ds_next.rem    = ge ? DW'(trial - {1'b0, ds_reg[k].den}) : DW'(trial);
            ds_next.num_lo = {ds_reg[k].num_lo[T-2:0], 1'b0};
            ds_next.q      = {ds_reg[k].q[T-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (pipe_en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
            if (pipe_en) begin
                ds_reg[k+1] <= ds_next;
            end
        end
    end

    // scale multiply, split in two partial products
    logic [T-1:0] tof_fin;
    assign tof_fin = (ds_reg[T].op == OP_SINGLE) ? ds_reg[T].tof_s : ds_reg[T].q;

    logic                  vm_reg;
    logic [1:0]            stm_reg;
    logic [LO+SCALE_W-1:0] plo_reg;
    logic [HI+SCALE_W-1:0] phi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (pipe_en) begin
            vm_reg <= dv_reg[T];
        end
        if (pipe_en) begin
            stm_reg <= ds_reg[T].st;
            plo_reg <= tof_fin[LO-1:0] * scale_reg;
            phi_reg <= tof_fin[T-1:LO] * scale_reg;
        end
    end

    // output stage: distance, range check
    logic [T+SCALE_W-1:0] prod_next;
    logic [DSW-1:0]       dist_next;
    twr_out_t             out_next;

    always_comb begin
        prod_next = ((T + SCALE_W)'(phi_reg) << LO) + (T + SCALE_W)'(plo_reg);
        dist_next = prod_next[T+SCALE_W-1:FRAC_SHIFT];
        out_next.status = (stm_reg == ST_OK && CW'(dist_next) > CW'(maxd_reg)) ?
                          ST_RANGE : stm_reg;
        out_next.valid_res    = (out_next.status == ST_OK);
        out_next.distance_q10 = out_next.valid_res ? dist_next[MAXD_W-1:0] : '0;
    end

    logic     out_v_reg;
    twr_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (pipe_en) begin
            out_v_reg <= vm_reg;
        end
        if (pipe_en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/twr_checker.sv =====
// ----------------------------------------------------------------------------
// twr_checker
// Port-level checks for the ranging distance pipeline.
// ----------------------------------------------------------------------------
module twr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input twr_pkg::twr_out_t m_data
);
    import twr_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // pipeline takes a request whenever the output slot frees
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with free output");

    // valid flag tracks status
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.valid_res == (m_data.status == ST_OK)))
        else $error("valid_res disagrees with status");

    // failed results carry no distance
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.distance_q10 == '0)
        else $error("distance on failed result");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result right after reset");

endmodule

bind twr_range_distance twr_checker u_twr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
